@@ sv/sbsd_pkg.sv @@
// Shared types, codes and helpers for the stitch byte stream decoder.
// Used by sbsd_parser, the top level and the port checker. No dependencies.
package sbsd_pkg;

   // Escape marker and the second bytes that follow it
   localparam logic [7:0] ESC_BYTE   = 8'h80;
   localparam logic [7:0] ESC_STOP   = 8'h01;
   localparam logic [7:0] ESC_TRIM_A = 8'h02;
   localparam logic [7:0] ESC_TRIM_B = 8'h04;
   localparam logic [7:0] ESC_END    = 8'h10;

   // An offset of +127 or -127 marks its own stitch and the next as a trim
   localparam logic [7:0] BIG_POS = 8'd127;
   localparam logic [7:0] BIG_NEG = 8'h81;

   // Stitch kinds carried on the result channel
   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_TRIM   = 2'd1;
   localparam logic [1:0] KIND_STOP   = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   // Parse phases
   localparam logic [1:0] PH_FIRST      = 2'd0;
   localparam logic [1:0] PH_SECOND     = 2'd1;
   localparam logic [1:0] PH_ESC_FIRST  = 2'd2;
   localparam logic [1:0] PH_ESC_SECOND = 2'd3;

   // One decoded stitch, with a flag saying whether the byte produced one
   typedef struct packed {
      logic       valid;
      logic [7:0] step_x;
      logic [7:0] step_y;
      logic [1:0] kind;
   } result_type;

   // True when the byte, read as two's complement, has magnitude 127
   function automatic logic is_big(input logic [7:0] b);
      return (b == BIG_POS) || (b == BIG_NEG);
   endfunction

endpackage

@@ sv/sbsd_parser.sv @@
// Byte pairing and escape decoding for the stitch byte stream decoder.
// Holds the parse state; depends on sbsd_pkg.
module sbsd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            data_byte,
   output sbsd_pkg::result_type  result
);

   logic [1:0] phase_ff,    phase_in;
   logic [7:0] held_ff,     held_in;
   logic       esc_trim_ff, esc_trim_in;
   logic       trim_ff,     trim_in;
   logic       done_ff,     done_in;
   logic       big;
   logic [1:0] base_kind;

   assign big = sbsd_pkg::is_big(held_ff) || sbsd_pkg::is_big(data_byte);

   // Decode the byte against the current phase
   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      esc_trim_in = esc_trim_ff;
      trim_in     = trim_ff;
      done_in     = done_ff;
      base_kind   = sbsd_pkg::KIND_NORMAL;
      result      = '0;
      if (!done_ff) begin
         unique case (phase_ff)
            sbsd_pkg::PH_FIRST: begin
               held_in  = data_byte;
               phase_in = sbsd_pkg::PH_SECOND;
            end
            sbsd_pkg::PH_SECOND: begin
               phase_in  = sbsd_pkg::PH_FIRST;
               base_kind = trim_ff ? sbsd_pkg::KIND_TRIM : sbsd_pkg::KIND_NORMAL;
               trim_in   = 1'b0;
               if (held_ff == sbsd_pkg::ESC_BYTE && data_byte == sbsd_pkg::ESC_STOP) begin
                  esc_trim_in = 1'b0;
                  phase_in    = sbsd_pkg::PH_ESC_FIRST;
               end else if (held_ff == sbsd_pkg::ESC_BYTE &&
                            (data_byte == sbsd_pkg::ESC_TRIM_A ||
                             data_byte == sbsd_pkg::ESC_TRIM_B)) begin
                  esc_trim_in = 1'b1;
                  trim_in     = 1'b1;
                  phase_in    = sbsd_pkg::PH_ESC_FIRST;
               end else if (held_ff == sbsd_pkg::ESC_BYTE &&
                            data_byte == sbsd_pkg::ESC_END) begin
                  done_in      = 1'b1;
                  result.valid = 1'b1;
                  result.kind  = sbsd_pkg::KIND_END;
               end else begin
                  result.valid  = 1'b1;
                  result.step_x = held_ff;
                  result.step_y = data_byte;
                  result.kind   = big ? sbsd_pkg::KIND_TRIM : base_kind;
                  if (big) begin
                     trim_in = 1'b1;
                  end
               end
            end
            sbsd_pkg::PH_ESC_FIRST: begin
               held_in  = data_byte;
               phase_in = sbsd_pkg::PH_ESC_SECOND;
            end
            sbsd_pkg::PH_ESC_SECOND: begin
               // Offset of the stop or trim; never a new escape
               phase_in      = sbsd_pkg::PH_FIRST;
               base_kind     = esc_trim_ff ? sbsd_pkg::KIND_TRIM : sbsd_pkg::KIND_STOP;
               result.valid  = 1'b1;
               result.step_x = held_ff;
               result.step_y = data_byte;
               result.kind   = big ? sbsd_pkg::KIND_TRIM : base_kind;
               if (big) begin
                  trim_in = 1'b1;
               end
            end
            default: begin
               phase_in = sbsd_pkg::PH_FIRST;
            end
         endcase
      end
   end

   // Advance the parse state on each consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sbsd_pkg::PH_FIRST;
         held_ff     <= '0;
         esc_trim_ff <= 1'b0;
         trim_ff     <= 1'b0;
         done_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         esc_trim_ff <= esc_trim_in;
         trim_ff     <= trim_in;
         done_ff     <= done_in;
      end
   end

endmodule

@@ sv/stitch_byte_stream_decoder_unit.sv @@
// Top level of the stitch byte stream decoder: input register, parser, result register.
// Depends on sbsd_pkg and sbsd_parser.
//
// Usage:
//   req_ channel carries one raw stitch-section byte per transaction.
//   rsp_ channel carries one decoded stitch (x, y offsets and its kind).
//   A transaction completes on a rising edge with valid high and stall low.
//   Bytes are paired; the first byte of a pair and a stop or trim escape
//   give no result, the second byte of any other pair gives one. After an
//   end record every further byte is taken and dropped.
// Path: a byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while rsp_stall is low; the decode is a single
//   pass of logic between the input register and the result register.
// Stalling: while rsp_stall holds a result, the input register still takes
//   one byte; req_stall rises only when both registers are full.
// Reset: synchronous, active high; clears the valid flags of both registers and
//   returns the parser to the first byte of a pair with no trim pending and no end seen.
module stitch_byte_stream_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_step_x,
   output logic signed [7:0] rsp_step_y,
   output logic [1:0]        rsp_stitch_kind
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_x_ff, out_y_ff;
   logic [1:0]           out_kind_ff;
   logic                 advance;
   logic                 fire;
   logic                 take;
   sbsd_pkg::result_type result;

   // Result register is free when empty or being taken this cycle
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   sbsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   // Hold the input byte until the parser consumes it
   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = fire && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load without reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
      end
      if (fire && result.valid) begin
         out_x_ff    <= result.step_x;
         out_y_ff    <= result.step_y;
         out_kind_ff <= result.kind;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_step_x      = $signed(out_x_ff);
   assign rsp_step_y      = $signed(out_y_ff);
   assign rsp_stitch_kind = out_kind_ff;

endmodule

@@ sv/sbsd_checker.sv @@
// Port-level checks for the stitch byte stream decoder, bound to the top level.
// Depends on sbsd_pkg.
module sbsd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [7:0] rsp_step_x,
   input logic signed [7:0] rsp_step_y,
   input logic [1:0]        rsp_stitch_kind
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Input back-pressure only when the result side is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side free");

   // End record carries zero offsets
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stitch_kind == sbsd_pkg::KIND_END |->
         rsp_step_x == 8'sd0 && rsp_step_y == 8'sd0)
      else $error("end record with non-zero offset");

   // Nothing follows a delivered end record
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_stitch_kind == sbsd_pkg::KIND_END |=> !rsp_valid)
      else $error("result after end record");

   // Reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stitch_byte_stream_decoder_unit sbsd_checker u_sbsd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_step_x      (rsp_step_x),
   .rsp_step_y      (rsp_step_y),
   .rsp_stitch_kind (rsp_stitch_kind)
);
